/* rtl/chained_range_remap_min_core_defines.svh */
// assertion macros shared by the checker of chained_range_remap_min_core
// no dependencies; every macro samples i_clk and is disabled while i_rst_n is low
`ifndef CHAINED_RANGE_REMAP_MIN_CORE_DEFINES_SVH
`define CHAINED_RANGE_REMAP_MIN_CORE_DEFINES_SVH

// antecedent and consequent in the same cycle
`define CRR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("crr checker: property violated");

// consequent starting in the cycle after the antecedent
`define CRR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("crr checker: property violated");

`endif

/* rtl/crr_pkg.sv */
// shared types, codes and stream layout for the chained range remap block
// no dependencies
package crr_pkg;

    localparam int DEF_STAGES     = 7;
    localparam int DEF_ENTRIES    = 64;
    localparam int DEF_VALUE_BITS = 32;

    localparam int FIELD_W     = 32;
    localparam int IN_TUSER_W  = 2;
    localparam int IN_TDATA_W  = 168;
    localparam int OUT_TDATA_W = 40;

    // input tdata bit offsets
    localparam int OFS_STAGE = 0;
    localparam int OFS_DEST  = 3;
    localparam int OFS_SRC   = 35;
    localparam int OFS_SPAN  = 67;
    localparam int OFS_FIRST = 99;
    localparam int OFS_COUNT = 131;
    localparam int STAGE_W   = 3;

    localparam logic [FIELD_W-1:0] LOWEST_NONE = '1;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_SCAN  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_STRETCH,
        S_ENT_READ,
        S_EVAL_A,
        S_EVAL_B,
        S_EVAL_C,
        S_NEXT,
        S_END_A,
        S_END_B,
        S_RESULT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_EXEC,
        OP_STRETCH,
        OP_READ,
        OP_EVAL_A,
        OP_EVAL_B,
        OP_EVAL_C,
        OP_NEXT,
        OP_END_A,
        OP_END_B,
        OP_RESULT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic is_scan;
        logic left_zero;
        logic k_done;
        logic stage_last;
        logic hit;
        logic out_free;
    } t_dp_stat;

endpackage

/* rtl/crr_ram.sv */
// generic single write port, single read port ram with registered read data
// no dependencies
module crr_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 448,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/crr_ctrl.sv */
// controller state machine: sequences accept, table walk, stretch steps and result
// depends on crr_pkg
module crr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  crr_pkg::t_dp_stat i_stat,
    output crr_pkg::t_dp_cmd  o_cmd
);

    crr_pkg::t_state r_state;
    crr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= crr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = crr_pkg::OP_NONE;
        o_s_tready = 1'b0;
        unique case (r_state)
            crr_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.op = crr_pkg::OP_ACCEPT;
                    n_state  = crr_pkg::S_EXEC;
                end
            end
            crr_pkg::S_EXEC: begin
                o_cmd.op = crr_pkg::OP_EXEC;
                n_state  = i_stat.is_scan ? crr_pkg::S_STRETCH : crr_pkg::S_RESULT;
            end
            crr_pkg::S_STRETCH: begin
                if (i_stat.left_zero) begin
                    n_state = crr_pkg::S_RESULT;
                end else begin
                    o_cmd.op = crr_pkg::OP_STRETCH;
                    n_state  = crr_pkg::S_ENT_READ;
                end
            end
            crr_pkg::S_ENT_READ: begin
                if (i_stat.k_done) begin
                    n_state = crr_pkg::S_NEXT;
                end else begin
                    o_cmd.op = crr_pkg::OP_READ;
                    n_state  = crr_pkg::S_EVAL_A;
                end
            end
            crr_pkg::S_EVAL_A: begin
                o_cmd.op = crr_pkg::OP_EVAL_A;
                n_state  = crr_pkg::S_EVAL_B;
            end
            crr_pkg::S_EVAL_B: begin
                o_cmd.op = crr_pkg::OP_EVAL_B;
                n_state  = i_stat.hit ? crr_pkg::S_EVAL_C : crr_pkg::S_ENT_READ;
            end
            crr_pkg::S_EVAL_C: begin
                o_cmd.op = crr_pkg::OP_EVAL_C;
                n_state  = crr_pkg::S_NEXT;
            end
            crr_pkg::S_NEXT: begin
                if (i_stat.stage_last) begin
                    n_state = crr_pkg::S_END_A;
                end else begin
                    o_cmd.op = crr_pkg::OP_NEXT;
                    n_state  = crr_pkg::S_ENT_READ;
                end
            end
            crr_pkg::S_END_A: begin
                o_cmd.op = crr_pkg::OP_END_A;
                n_state  = crr_pkg::S_END_B;
            end
            crr_pkg::S_END_B: begin
                o_cmd.op = crr_pkg::OP_END_B;
                n_state  = crr_pkg::S_STRETCH;
            end
            crr_pkg::S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = crr_pkg::OP_RESULT;
                    n_state  = crr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = crr_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/crr_dpath.sv */
// datapath: input capture, stage fill counts, range table ram, stretch arithmetic,
// lowest value and output register; depends on crr_pkg and crr_ram
module crr_dpath #(
    parameter int STAGES     = crr_pkg::DEF_STAGES,
    parameter int ENTRIES    = crr_pkg::DEF_ENTRIES,
    parameter int VALUE_BITS = crr_pkg::DEF_VALUE_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  crr_pkg::t_dp_cmd                i_cmd,
    output crr_pkg::t_dp_stat               o_stat,
    input  logic [crr_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic [crr_pkg::IN_TUSER_W-1:0]  i_s_tuser,
    input  logic                            i_m_tready,
    output logic                            o_m_tvalid,
    output logic [crr_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int SW    = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam int FW    = $clog2(ENTRIES + 1);
    localparam int DEPTH = STAGES * ENTRIES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VB    = VALUE_BITS;
    localparam int CW    = ((VB > crr_pkg::FIELD_W) ? VB : crr_pkg::FIELD_W) + 1;
    localparam int FLD   = crr_pkg::FIELD_W;
    localparam int RW    = 3 * FLD;

    // captured item
    crr_pkg::t_cmd   r_cmd;
    logic [SW-1:0]   r_ld_stage;
    logic            r_ld_ok;
    logic [FLD-1:0]  r_dest;
    logic [FLD-1:0]  r_src;
    logic [FLD-1:0]  r_span;
    logic            r_drop;

    // scan state
    logic [VB-1:0]   r_v;
    logic [FLD-1:0]  r_left;
    logic [VB-1:0]   r_n;
    logic [CW-1:0]   r_room;
    logic [CW-1:0]   r_diff;
    logic [CW-1:0]   r_gap;
    logic [FLD-1:0]  r_step;
    logic [SW-1:0]   r_stage;
    logic [FW-1:0]   r_k;

    logic [FW-1:0]   r_fill [STAGES];
    logic [FLD-1:0]  r_lowest;
    logic            r_out_valid;
    logic [FLD-1:0]  r_out_lowest;
    logic            r_out_drop;

    logic [SW-1:0]   w_fidx;
    logic [FW-1:0]   w_fill_sel;
    logic            w_full;
    logic            w_we;
    logic [AW-1:0]   w_waddr;
    logic [AW-1:0]   w_raddr;
    logic [RW-1:0]   w_rdata;
    logic [FLD-1:0]  w_dest;
    logic [FLD-1:0]  w_lo;
    logic [FLD-1:0]  w_len;
    logic            w_hit;
    logic            w_cand_ok;
    logic [CW-1:0]   w_cand;
    logic [CW-1:0]   w_top;
    logic [CW-1:0]   w_n_ext;
    logic [FLD-1:0]  w_final;
    logic            w_out_free;
    logic [2:0]      w_in_stage;

    assign w_in_stage = i_s_tdata[crr_pkg::OFS_STAGE +: crr_pkg::STAGE_W];

    // fill count of the stage being loaded or walked
    assign w_fidx = (r_cmd == crr_pkg::CMD_SCAN) ? r_stage : r_ld_stage;

    always_comb begin
        w_fill_sel = '0;
        for (int s = 0; s < STAGES; s++) begin
            if (w_fidx == SW'(s)) begin
                w_fill_sel = r_fill[s];
            end
        end
    end

    assign w_full  = (w_fill_sel >= FW'(ENTRIES));
    assign w_we    = (i_cmd.op == crr_pkg::OP_EXEC) && (r_cmd == crr_pkg::CMD_LOAD)
                     && r_ld_ok && !w_full;
    assign w_waddr = AW'(r_ld_stage) * AW'(ENTRIES) + AW'(w_fill_sel);
    assign w_raddr = AW'(r_stage) * AW'(ENTRIES) + AW'(r_k);

    crr_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({r_dest, r_src, r_span}),
        .i_re    (i_cmd.op == crr_pkg::OP_READ),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_dest = w_rdata[2*FLD +: FLD];
    assign w_lo   = w_rdata[FLD +: FLD];
    assign w_len  = w_rdata[0 +: FLD];

    // entry match and candidate stretch bound
    assign w_hit     = !r_diff[CW-1] && (r_diff < CW'(w_len));
    assign w_cand_ok = w_hit || (r_diff[CW-1] && (w_len != '0));
    assign w_cand    = w_hit ? (CW'(w_len) - r_diff) : r_gap;
    assign w_top     = (CW'(1) << VB) - CW'(r_n);

    assign w_n_ext = CW'(r_n);
    assign w_final = (w_n_ext > CW'(crr_pkg::LOWEST_NONE)) ? crr_pkg::LOWEST_NONE
                                                           : w_n_ext[FLD-1:0];

    assign w_out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < STAGES; s++) begin
                r_fill[s] <= '0;
            end
            r_lowest    <= crr_pkg::LOWEST_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == crr_pkg::OP_EXEC) begin
                if (r_cmd == crr_pkg::CMD_CLEAR) begin
                    for (int s = 0; s < STAGES; s++) begin
                        r_fill[s] <= '0;
                    end
                    r_lowest <= crr_pkg::LOWEST_NONE;
                end else if (w_we) begin
                    for (int s = 0; s < STAGES; s++) begin
                        if (r_ld_stage == SW'(s)) begin
                            r_fill[s] <= w_fill_sel + 1'b1;
                        end
                    end
                end
            end
            if ((i_cmd.op == crr_pkg::OP_END_A) && (w_final < r_lowest)) begin
                r_lowest <= w_final;
            end
            if (i_cmd.op == crr_pkg::OP_RESULT) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            crr_pkg::OP_NONE, crr_pkg::OP_READ: begin
            end
            crr_pkg::OP_ACCEPT: begin
                r_cmd      <= crr_pkg::t_cmd'(i_s_tuser);
                r_ld_stage <= SW'(w_in_stage);
                r_ld_ok    <= ({29'd0, w_in_stage} < 32'(STAGES));
                r_dest     <= i_s_tdata[crr_pkg::OFS_DEST +: FLD];
                r_src      <= i_s_tdata[crr_pkg::OFS_SRC +: FLD];
                r_span     <= i_s_tdata[crr_pkg::OFS_SPAN +: FLD];
                r_v        <= VB'(i_s_tdata[crr_pkg::OFS_FIRST +: FLD]);
                r_left     <= i_s_tdata[crr_pkg::OFS_COUNT +: FLD];
                r_drop     <= 1'b0;
            end
            crr_pkg::OP_EXEC: begin
                if ((r_cmd == crr_pkg::CMD_LOAD) && r_ld_ok && w_full) begin
                    r_drop <= 1'b1;
                end
            end
            crr_pkg::OP_STRETCH: begin
                r_room  <= (CW'(1) << VB) - CW'(r_v);
                r_n     <= r_v;
                r_stage <= '0;
                r_k     <= '0;
            end
            crr_pkg::OP_EVAL_A: begin
                r_diff <= CW'(r_n) - CW'(w_lo);
                r_gap  <= CW'(w_lo) - CW'(r_n);
            end
            crr_pkg::OP_EVAL_B: begin
                if (w_hit) begin
                    r_n <= VB'(r_diff + CW'(w_dest));
                end else begin
                    r_k <= r_k + 1'b1;
                end
                if (w_cand_ok && (w_cand < r_room)) begin
                    r_room <= w_cand;
                end
            end
            crr_pkg::OP_EVAL_C: begin
                if (w_top < r_room) begin
                    r_room <= w_top;
                end
            end
            crr_pkg::OP_NEXT: begin
                r_stage <= r_stage + 1'b1;
                r_k     <= '0;
            end
            crr_pkg::OP_END_A: begin
                r_step <= (r_room < CW'(r_left)) ? r_room[FLD-1:0] : r_left;
            end
            crr_pkg::OP_END_B: begin
                r_v    <= VB'(CW'(r_v) + CW'(r_step));
                r_left <= r_left - r_step;
            end
            crr_pkg::OP_RESULT: begin
                r_out_lowest <= r_lowest;
                r_out_drop   <= r_drop;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.is_scan    = (r_cmd == crr_pkg::CMD_SCAN);
    assign o_stat.left_zero  = (r_left == '0);
    assign o_stat.k_done     = (r_k >= w_fill_sel);
    assign o_stat.stage_last = (r_stage == SW'(STAGES - 1));
    assign o_stat.hit        = w_hit;
    assign o_stat.out_free   = w_out_free;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(crr_pkg::OUT_TDATA_W - FLD - 1){1'b0}}, r_out_drop, r_out_lowest};

endmodule

/* rtl/chained_range_remap_min_core.sv */
// Chained range remap with running minimum. Each transaction on the slave side carries a
// command in tuser: load appends a (destination, source, span) entry to one stage table
// (dropped with a flag when the table is full), scan sends a run of values through every
// stage in turn and keeps the lowest final value, clear empties the tables and resets the
// lowest value. Every transaction yields one result transaction holding the lowest value
// and the drop flag. Load, clear and no-op go from acceptance through the exec state to the
// result register. A scan then handles each stretch of the run on which every stage is one
// translation, walking every stage in turn and testing its entries one at a time until one
// matches; the range table ram, with one write and one read port, holds STAGES * ENTRIES
// entries and needs no clearing after reset. A new transaction is taken while the previous
// result still waits on the master side.
// depends on crr_pkg, crr_ctrl, crr_dpath, crr_ram
module chained_range_remap_min_core #(
    parameter int STAGES     = crr_pkg::DEF_STAGES,
    parameter int ENTRIES    = crr_pkg::DEF_ENTRIES,
    parameter int VALUE_BITS = crr_pkg::DEF_VALUE_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // stage[2:0], dest_start[34:3], src_start[66:35], span[98:67],
    // first_value[130:99], value_count[162:131], zero pad
    input  logic [crr_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // cmd[1:0]
    input  logic [crr_pkg::IN_TUSER_W-1:0]  i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // lowest[31:0], entry_dropped[32], zero pad
    output logic [crr_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    crr_pkg::t_dp_cmd  w_cmd;
    crr_pkg::t_dp_stat w_stat;

    crr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    crr_dpath #(
        .STAGES     (STAGES),
        .ENTRIES    (ENTRIES),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

/* rtl/crr_checker.sv */
// port level checker for chained_range_remap_min_core, bound to the top level
// depends on crr_pkg and chained_range_remap_min_core_defines.svh
`include "chained_range_remap_min_core_defines.svh"

module crr_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic [crr_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input logic [crr_pkg::IN_TUSER_W-1:0]  i_s_tuser,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [crr_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    // an accept keeps the slave side closed in exec and in stretch or result
    `CRR_ASSERT_NEXT(a_busy_after_accept, i_s_tvalid && o_s_tready, !o_s_tready ##1 !o_s_tready)

    // a stalled result holds
    `CRR_ASSERT_NEXT(a_result_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))

    // pad bits above the drop flag stay zero
    `CRR_ASSERT_SAME(a_pad_zero, o_m_tvalid, o_m_tdata[crr_pkg::OUT_TDATA_W-1:33] == '0)

endmodule

bind chained_range_remap_min_core crr_checker u_crr_checker (.*);
